@@ rtl/fprm_pkg.sv @@
// ---------------------------------------------------------------------------
// fprm_pkg
// Shared sizes, codes and types of the FIFO push-relabel max-flow engine.
// ---------------------------------------------------------------------------
package fprm_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int MAX_DEGREE    = 16;
  localparam int CAPACITY_BITS = 16;

  localparam int VTX_W      = $clog2(MAX_VERTICES);
  localparam int NV_W       = $clog2(MAX_VERTICES + 1);
  localparam int SLOT_W     = $clog2(MAX_DEGREE);
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_AW    = VTX_W + SLOT_W;
  localparam int SLOT_DW    = VTX_W + SLOT_W + CAPACITY_BITS;
  localparam int FLOW_W     = CAPACITY_BITS + 1;
  localparam int EXC_W      = CAPACITY_BITS + SLOT_W + 1;
  localparam int DATA_W     = EXC_W + 1;
  localparam int AMT_W      = CAPACITY_BITS + 2;
  localparam int HGT_W      = 16;
  localparam int STEP_W     = NV_W + 1;
  localparam int ITER_W     = 24;
  localparam int OUT_FLOW_W = 20;
  localparam int CFG_AW     = 2;

  localparam logic [HGT_W-1:0]      HEIGHT_MAX   = '1;
  localparam logic [OUT_FLOW_W-1:0] FLOW_OUT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_SOLVE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LIMIT  = 2'd1,
    ST_BAD_ST = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_NUM_VERTICES = 2'd0,
    CFG_SOURCE       = 2'd1,
    CFG_SINK         = 2'd2,
    CFG_ITER_LIMIT   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

@@ rtl/fprm_ram.sv @@
// ---------------------------------------------------------------------------
// fprm_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module fprm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fprm_alu.sv @@
// ---------------------------------------------------------------------------
// fprm_alu
// Shared add/subtract unit with signed less-than, used by the solve sequencer.
// ---------------------------------------------------------------------------
module fprm_alu (
  input  fprm_pkg::alu_op_t op,
  input  fprm_pkg::word_t   a,
  input  fprm_pkg::word_t   b,
  output fprm_pkg::word_t   res,
  output logic              lt
);
  import fprm_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

  assign lt = (a < b);

endmodule

@@ rtl/fifo_push_relabel_max_flow.sv @@
// ---------------------------------------------------------------------------
// fifo_push_relabel_max_flow
// Edge loader and FIFO push-relabel maximum flow solver.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_*  : plain write port; user writes only while block is idle, unenforced.
//   in_*   : one command per transfer: clear the network, add an edge, or
//            solve. in_ready is high only while the sequencer is idle.
//   out_*  : exactly one result per command, held in an output register
//            until taken; the block goes back to idle once the result is
//            loaded there, so a stalled receiver holds at most one result
//            and stalls the next command only when a second one is ready.
// Work per command (from transfer to result register):
//   clear / unused command : straight to the result
//   add edge               : two degree reads, two slot writes
//   solve                  : a sweep that zeroes all 1024 flow slots, then
//            saturate each source slot, pop vertices and push or relabel over
//            their slots, then sum the flow on the source slots.
// Each store has one write port and one read port, and there is one shared
// adder; one command is worked on at a time.
// Reset clears degrees (empty network) and the queue, and sets the configuration
// registers (64 vertices, source 0, sink 1, limit 1000000).
// ---------------------------------------------------------------------------
module fifo_push_relabel_max_flow (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [fprm_pkg::CFG_AW-1:0]            cfg_index,
  input  logic [fprm_pkg::ITER_W-1:0]            cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_action,
  input  logic [fprm_pkg::VTX_W-1:0]             in_from_vertex,
  input  logic [fprm_pkg::VTX_W-1:0]             in_to_vertex,
  input  logic [fprm_pkg::CAPACITY_BITS-1:0]     in_capacity,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [fprm_pkg::OUT_FLOW_W-1:0]        out_max_flow,
  output logic [1:0]                             out_status,
  output logic [fprm_pkg::ITER_W-1:0]            out_iteration_count
);
  import fprm_pkg::*;

  typedef enum logic [33:0] {
    S_IDLE    = 34'b1 << 0,
    S_DONE    = 34'b1 << 1,
    S_AE_RA   = 34'b1 << 2,
    S_AE_RB   = 34'b1 << 3,
    S_AE_CHK  = 34'b1 << 4,
    S_AE_W1   = 34'b1 << 5,
    S_AE_W2   = 34'b1 << 6,
    S_SV_CLR  = 34'b1 << 7,
    S_SV_HS   = 34'b1 << 8,
    S_SV_DEG  = 34'b1 << 9,
    S_SAT_RD  = 34'b1 << 10,
    S_SAT_W1  = 34'b1 << 11,
    S_SAT_W2  = 34'b1 << 12,
    S_SAT_W3  = 34'b1 << 13,
    S_LOOP    = 34'b1 << 14,
    S_POP     = 34'b1 << 15,
    S_LDU     = 34'b1 << 16,
    S_CHK     = 34'b1 << 17,
    S_PS_RD   = 34'b1 << 18,
    S_PS_HT   = 34'b1 << 19,
    S_PS_CMP  = 34'b1 << 20,
    S_PS_AMT  = 34'b1 << 21,
    S_PS_W1   = 34'b1 << 22,
    S_PS_W2   = 34'b1 << 23,
    S_PS_W3   = 34'b1 << 24,
    S_PS_W4   = 34'b1 << 25,
    S_RL_RD   = 34'b1 << 26,
    S_RL_HT   = 34'b1 << 27,
    S_RL_CMP  = 34'b1 << 28,
    S_RL_END  = 34'b1 << 29,
    S_END_D   = 34'b1 << 30,
    S_SUM_RD  = 34'b1 << 31,
    S_SUM_ADD = 34'b1 << 32,
    S_FIN     = 34'b1 << 33
  } state_t;

  state_t st_r;

  // configuration
  logic [NV_W-1:0]   nv_r;
  logic [VTX_W-1:0]  src_r;
  logic [VTX_W-1:0]  snk_r;
  logic [ITER_W-1:0] lim_r;
  logic [NV_W-1:0]   n_eff;

  // command
  logic [VTX_W-1:0]         a_r, b_r;
  logic [CAPACITY_BITS-1:0] cap_r;
  logic [DEG_W-1:0]         da_r, db_r;
  logic [SLOT_W-1:0]        sa_r, sb_r;

  // solve working registers
  logic [SLOT_AW-1:0]       clr_r;
  logic [DEG_W-1:0]         degs_r, degu_r, idx_r;
  logic [VTX_W-1:0]         u_r, w_r;
  logic [SLOT_W-1:0]        prt_r;
  logic [FLOW_W-1:0]        flw_r;
  logic [EXC_W-1:0]         exu_r;
  logic [HGT_W-1:0]         hu_r, best_r, newh;
  logic                     found_r;
  logic [AMT_W-1:0]         room_r, amt_r;
  logic [STEP_W-1:0]        steps_r;
  logic [ITER_W-1:0]        iters_r;
  word_t                    total_r;

  // queue
  logic [VTX_W-1:0]        head_r, tail_r;
  logic [NV_W-1:0]         qcnt_r;
  logic [MAX_VERTICES-1:0] qflag_r;
  logic                    enq_req, enq_ok;
  logic [VTX_W-1:0]        enq_v;

  // valid bits of the vertex stores
  logic [MAX_VERTICES-1:0] deg_vld_r, exc_vld_r, hgt_vld_r;
  logic                    deg_rv_r, exc_rv_r, hgt_rv_r;

  // results
  logic [OUT_FLOW_W-1:0] res_flow_r, out_flow_r;
  status_t               res_status_r, out_status_r;
  logic [ITER_W-1:0]     res_iter_r, out_iter_r;
  logic                  out_valid_r;

  // memory ports
  logic                 slot_we, slot_re;
  logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;
  logic [SLOT_DW-1:0]   slot_wdata, slot_q;
  logic                 flow_we, flow_re;
  logic [SLOT_AW-1:0]   flow_waddr, flow_raddr;
  logic [FLOW_W-1:0]    flow_wdata, flow_q;
  logic                 deg_we, deg_re;
  logic [VTX_W-1:0]     deg_waddr, deg_raddr;
  logic [DEG_W-1:0]     deg_wdata, deg_q;
  logic                 exc_we, exc_re;
  logic [VTX_W-1:0]     exc_waddr, exc_raddr;
  logic [EXC_W-1:0]     exc_wdata, exc_q;
  logic                 hgt_we, hgt_re;
  logic [VTX_W-1:0]     hgt_waddr, hgt_raddr;
  logic [HGT_W-1:0]     hgt_wdata, hgt_q;
  logic                 que_re;
  logic [VTX_W-1:0]     que_q;

  logic [VTX_W-1:0]         s_tgt;
  logic [SLOT_W-1:0]        s_prt;
  logic [CAPACITY_BITS-1:0] s_cap;
  logic [DEG_W-1:0]         deg_d;
  logic [EXC_W-1:0]         exc_d;
  logic [HGT_W-1:0]         hgt_d;
  word_t                    flow_sx, flw_sx;

  alu_op_t alu_op;
  word_t   alu_a, alu_b, alu_res;
  logic    alu_lt, alu_pos;

  assign n_eff = (nv_r > NV_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : nv_r;

  assign {s_tgt, s_prt, s_cap} = slot_q;
  assign deg_d   = deg_rv_r ? deg_q : '0;
  assign exc_d   = exc_rv_r ? exc_q : '0;
  assign hgt_d   = hgt_rv_r ? hgt_q : '0;
  assign flow_sx = {{(DATA_W-FLOW_W){flow_q[FLOW_W-1]}}, flow_q};
  assign flw_sx  = {{(DATA_W-FLOW_W){flw_r[FLOW_W-1]}}, flw_r};
  assign alu_pos = !alu_res[DATA_W-1] && (alu_res != '0);
  assign newh    = (best_r == HEIGHT_MAX) ? HEIGHT_MAX : best_r + 1'b1;
  assign enq_ok  = enq_req && !qflag_r[enq_v] && (qcnt_r < NV_W'(MAX_VERTICES));

  fprm_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES * MAX_DEGREE), .WIDTH(SLOT_DW)) u_slot_ram (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_q)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES * MAX_DEGREE), .WIDTH(FLOW_W)) u_flow_ram (
    .clk, .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
    .re(flow_re), .raddr(flow_raddr), .rdata(flow_q)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DEG_W)) u_deg_ram (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .re(deg_re), .raddr(deg_raddr), .rdata(deg_q)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(EXC_W)) u_exc_ram (
    .clk, .we(exc_we), .waddr(exc_waddr), .wdata(exc_wdata),
    .re(exc_re), .raddr(exc_raddr), .rdata(exc_q)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(HGT_W)) u_hgt_ram (
    .clk, .we(hgt_we), .waddr(hgt_waddr), .wdata(hgt_wdata),
    .re(hgt_re), .raddr(hgt_raddr), .rdata(hgt_q)
  );

  fprm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VTX_W)) u_que_ram (
    .clk, .we(enq_ok), .waddr(tail_r), .wdata(enq_v),
    .re(que_re), .raddr(head_r), .rdata(que_q)
  );

  // memory port and shared unit steering
  always_comb begin
    slot_we = 1'b0; slot_waddr = '0; slot_wdata = '0;
    slot_re = 1'b0; slot_raddr = '0;
    flow_we = 1'b0; flow_waddr = '0; flow_wdata = '0;
    flow_re = 1'b0; flow_raddr = '0;
    deg_we  = 1'b0; deg_waddr  = '0; deg_wdata  = '0;
    deg_re  = 1'b0; deg_raddr  = '0;
    exc_we  = 1'b0; exc_waddr  = '0; exc_wdata  = '0;
    exc_re  = 1'b0; exc_raddr  = '0;
    hgt_we  = 1'b0; hgt_waddr  = '0; hgt_wdata  = '0;
    hgt_re  = 1'b0; hgt_raddr  = '0;
    que_re  = 1'b0;
    enq_req = 1'b0; enq_v = '0;
    alu_op  = ALU_ADD; alu_a = '0; alu_b = '0;
    unique case (st_r)
      S_AE_RA: begin
        deg_re = 1'b1; deg_raddr = a_r;
      end
      S_AE_RB: begin
        deg_re = 1'b1; deg_raddr = b_r;
      end
      S_AE_W1: begin
        slot_we = 1'b1; slot_waddr = {a_r, sa_r}; slot_wdata = {b_r, sb_r, cap_r};
        flow_we = 1'b1; flow_waddr = {a_r, sa_r};
        deg_we  = 1'b1; deg_waddr  = a_r;
        deg_wdata = da_r + ((a_r == b_r) ? DEG_W'(2) : DEG_W'(1));
      end
      S_AE_W2: begin
        slot_we = 1'b1; slot_waddr = {b_r, sb_r};
        slot_wdata = {a_r, sa_r, {CAPACITY_BITS{1'b0}}};
        flow_we = 1'b1; flow_waddr = {b_r, sb_r};
        deg_we  = (a_r != b_r); deg_waddr = b_r; deg_wdata = db_r + 1'b1;
      end
      S_SV_CLR: begin
        flow_we = 1'b1; flow_waddr = clr_r;
      end
      S_SV_HS: begin
        hgt_we = 1'b1; hgt_waddr = src_r; hgt_wdata = HGT_W'(n_eff);
        deg_re = 1'b1; deg_raddr = src_r;
      end
      S_SAT_RD: begin
        slot_re = (idx_r != degs_r); slot_raddr = {src_r, idx_r[SLOT_W-1:0]};
      end
      S_SAT_W1: begin
        flow_we = 1'b1; flow_waddr = {src_r, idx_r[SLOT_W-1:0]};
        flow_wdata = {1'b0, s_cap};
        exc_re = 1'b1; exc_raddr = s_tgt;
      end
      S_SAT_W2: begin
        alu_op = ALU_SUB; alu_b = {{(DATA_W-CAPACITY_BITS){1'b0}}, cap_r};
        flow_we = 1'b1; flow_waddr = {w_r, prt_r}; flow_wdata = alu_res[FLOW_W-1:0];
      end
      S_SAT_W3: begin
        alu_a = {1'b0, exc_d}; alu_b = {{(DATA_W-CAPACITY_BITS){1'b0}}, cap_r};
        exc_we = 1'b1; exc_waddr = w_r; exc_wdata = alu_res[EXC_W-1:0];
        enq_req = (w_r != src_r) && (w_r != snk_r) && alu_pos; enq_v = w_r;
      end
      S_LOOP: begin
        que_re = 1'b1;
      end
      S_POP: begin
        exc_re = 1'b1; exc_raddr = que_q;
        hgt_re = 1'b1; hgt_raddr = que_q;
        deg_re = 1'b1; deg_raddr = que_q;
      end
      S_PS_RD, S_RL_RD: begin
        slot_re = (idx_r != degu_r); slot_raddr = {u_r, idx_r[SLOT_W-1:0]};
        flow_re = (idx_r != degu_r); flow_raddr = {u_r, idx_r[SLOT_W-1:0]};
      end
      S_PS_HT: begin
        hgt_re = 1'b1; hgt_raddr = s_tgt;
      end
      S_PS_CMP: begin
        alu_op = ALU_SUB; alu_a = {{(DATA_W-CAPACITY_BITS){1'b0}}, cap_r};
        alu_b = flw_sx;
      end
      S_PS_AMT: begin
        alu_op = ALU_SUB; alu_a = {1'b0, exu_r};
        alu_b = {{(DATA_W-AMT_W){1'b0}}, room_r};
        exc_re  = 1'b1; exc_raddr  = w_r;
        flow_re = 1'b1; flow_raddr = {w_r, prt_r};
      end
      S_PS_W1: begin
        alu_a = flw_sx; alu_b = {{(DATA_W-AMT_W){1'b0}}, amt_r};
        flow_we = 1'b1; flow_waddr = {u_r, idx_r[SLOT_W-1:0]};
        flow_wdata = alu_res[FLOW_W-1:0];
      end
      S_PS_W2: begin
        alu_op = ALU_SUB; alu_a = flow_sx; alu_b = {{(DATA_W-AMT_W){1'b0}}, amt_r};
        flow_we = 1'b1; flow_waddr = {w_r, prt_r}; flow_wdata = alu_res[FLOW_W-1:0];
      end
      S_PS_W3: begin
        alu_a = {1'b0, exc_d}; alu_b = {{(DATA_W-AMT_W){1'b0}}, amt_r};
        exc_we = 1'b1; exc_waddr = w_r; exc_wdata = alu_res[EXC_W-1:0];
        enq_req = alu_pos; enq_v = w_r;
      end
      S_PS_W4: begin
        alu_op = ALU_SUB; alu_a = {1'b0, exu_r};
        alu_b = {{(DATA_W-AMT_W){1'b0}}, amt_r};
      end
      S_RL_HT: begin
        alu_op = ALU_SUB; alu_a = {{(DATA_W-CAPACITY_BITS){1'b0}}, s_cap};
        alu_b = flow_sx;
        hgt_re = alu_pos; hgt_raddr = s_tgt;
      end
      S_RL_CMP: begin
        alu_op = ALU_SUB; alu_a = {{(DATA_W-HGT_W){1'b0}}, hgt_d};
        alu_b = {{(DATA_W-HGT_W){1'b0}}, best_r};
      end
      S_RL_END: begin
        hgt_we = found_r; hgt_waddr = u_r; hgt_wdata = newh;
      end
      S_END_D: begin
        exc_we = 1'b1; exc_waddr = u_r; exc_wdata = exu_r;
        enq_req = (exu_r != '0); enq_v = u_r;
      end
      S_SUM_RD: begin
        flow_re = (idx_r != degs_r); flow_raddr = {src_r, idx_r[SLOT_W-1:0]};
      end
      S_SUM_ADD: begin
        alu_a = total_r; alu_b = flow_sx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      nv_r        <= NV_W'(MAX_VERTICES);
      src_r       <= VTX_W'(0);
      snk_r       <= VTX_W'(1);
      lim_r       <= ITER_W'(1000000);
      deg_vld_r   <= '0;
      exc_vld_r   <= '0;
      hgt_vld_r   <= '0;
      qflag_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      qcnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_NUM_VERTICES: nv_r  <= cfg_wr_data[NV_W-1:0];
          CFG_SOURCE:       src_r <= cfg_wr_data[VTX_W-1:0];
          CFG_SINK:         snk_r <= cfg_wr_data[VTX_W-1:0];
          CFG_ITER_LIMIT:   lim_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end

      if (deg_re) deg_rv_r <= deg_vld_r[deg_raddr];
      if (exc_re) exc_rv_r <= exc_vld_r[exc_raddr];
      if (hgt_re) hgt_rv_r <= hgt_vld_r[hgt_raddr];
      if (deg_we) deg_vld_r[deg_waddr] <= 1'b1;
      if (exc_we) exc_vld_r[exc_waddr] <= 1'b1;
      if (hgt_we) hgt_vld_r[hgt_waddr] <= 1'b1;

      if (enq_ok) begin
        tail_r         <= tail_r + 1'b1;
        qcnt_r         <= qcnt_r + 1'b1;
        qflag_r[enq_v] <= 1'b1;
      end

      // a new result may replace the one being taken in the same cycle
      if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r          <= in_from_vertex;
            b_r          <= in_to_vertex;
            cap_r        <= in_capacity;
            res_flow_r   <= '0;
            res_status_r <= ST_OK;
            res_iter_r   <= '0;
            unique case (action_t'(in_action))
              ACT_CLEAR: begin
                deg_vld_r <= '0;
                st_r      <= S_DONE;
              end
              ACT_ADD: begin
                if ({1'b0, in_from_vertex} >= n_eff || {1'b0, in_to_vertex} >= n_eff) begin
                  res_status_r <= ST_REJECT;
                  st_r         <= S_DONE;
                end else begin
                  st_r <= S_AE_RA;
                end
              end
              ACT_SOLVE: begin
                if ({1'b0, src_r} >= n_eff || {1'b0, snk_r} >= n_eff || src_r == snk_r) begin
                  res_status_r <= ST_BAD_ST;
                  st_r         <= S_DONE;
                end else begin
                  exc_vld_r <= '0;
                  hgt_vld_r <= '0;
                  qflag_r   <= '0;
                  head_r    <= '0;
                  tail_r    <= '0;
                  qcnt_r    <= '0;
                  iters_r   <= '0;
                  clr_r     <= '0;
                  st_r      <= S_SV_CLR;
                end
              end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_AE_RA: st_r <= S_AE_RB;
        S_AE_RB: begin
          da_r <= deg_d;
          st_r <= S_AE_CHK;
        end
        S_AE_CHK: begin
          if (a_r == b_r) begin
            if ({1'b0, da_r} + 2'd2 > (DEG_W + 1)'(MAX_DEGREE)) begin
              res_status_r <= ST_REJECT;
              st_r         <= S_DONE;
            end else begin
              sa_r <= da_r[SLOT_W-1:0];
              sb_r <= da_r[SLOT_W-1:0] + 1'b1;
              st_r <= S_AE_W1;
            end
          end else if (da_r >= DEG_W'(MAX_DEGREE) || deg_d >= DEG_W'(MAX_DEGREE)) begin
            res_status_r <= ST_REJECT;
            st_r         <= S_DONE;
          end else begin
            sa_r <= da_r[SLOT_W-1:0];
            sb_r <= deg_d[SLOT_W-1:0];
            db_r <= deg_d;
            st_r <= S_AE_W1;
          end
        end
        S_AE_W1: st_r <= S_AE_W2;
        S_AE_W2: st_r <= S_DONE;
        // zero every flow slot, one per cycle
        S_SV_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_SV_HS;
        end
        S_SV_HS: st_r <= S_SV_DEG;
        S_SV_DEG: begin
          degs_r <= deg_d;
          idx_r  <= '0;
          st_r   <= S_SAT_RD;
        end
        S_SAT_RD: begin
          if (idx_r == degs_r) st_r <= S_LOOP;
          else                 st_r <= S_SAT_W1;
        end
        S_SAT_W1: begin
          w_r   <= s_tgt;
          prt_r <= s_prt;
          cap_r <= s_cap;
          st_r  <= S_SAT_W2;
        end
        S_SAT_W2: st_r <= S_SAT_W3;
        S_SAT_W3: begin
          idx_r <= idx_r + 1'b1;
          st_r  <= S_SAT_RD;
        end
        S_LOOP: begin
          if (qcnt_r != '0 && iters_r < lim_r) begin
            st_r <= S_POP;
          end else begin
            idx_r   <= '0;
            total_r <= '0;
            st_r    <= S_SUM_RD;
          end
        end
        S_POP: begin
          u_r            <= que_q;
          head_r         <= head_r + 1'b1;
          qcnt_r         <= qcnt_r - 1'b1;
          qflag_r[que_q] <= 1'b0;
          iters_r        <= iters_r + 1'b1;
          // source and sink pops count but do no work
          if (que_q == src_r || que_q == snk_r) st_r <= S_LOOP;
          else                                  st_r <= S_LDU;
        end
        S_LDU: begin
          exu_r   <= exc_d;
          hu_r    <= hgt_d;
          degu_r  <= deg_d;
          steps_r <= '0;
          st_r    <= S_CHK;
        end
        S_CHK: begin
          if (exu_r != '0 && steps_r < {n_eff, 1'b0}) begin
            idx_r <= '0;
            st_r  <= S_PS_RD;
          end else begin
            st_r <= S_END_D;
          end
        end
        S_PS_RD: begin
          if (idx_r == degu_r) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            st_r    <= S_RL_RD;
          end else begin
            st_r <= S_PS_HT;
          end
        end
        S_PS_HT: begin
          w_r   <= s_tgt;
          prt_r <= s_prt;
          cap_r <= s_cap;
          flw_r <= flow_q;
          st_r  <= S_PS_CMP;
        end
        S_PS_CMP: begin
          if (alu_pos && ({1'b0, hu_r} == {1'b0, hgt_d} + 1'b1)) begin
            room_r <= alu_res[AMT_W-1:0];
            st_r   <= S_PS_AMT;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_PS_RD;
          end
        end
        S_PS_AMT: begin
          amt_r <= alu_lt ? AMT_W'(exu_r) : room_r;
          st_r  <= S_PS_W1;
        end
        S_PS_W1: st_r <= S_PS_W2;
        S_PS_W2: st_r <= S_PS_W3;
        S_PS_W3: st_r <= S_PS_W4;
        S_PS_W4: begin
          exu_r   <= alu_res[EXC_W-1:0];
          steps_r <= steps_r + 1'b1;
          st_r    <= S_CHK;
        end
        S_RL_RD: begin
          if (idx_r == degu_r) st_r <= S_RL_END;
          else                 st_r <= S_RL_HT;
        end
        S_RL_HT: begin
          if (alu_pos) begin
            st_r <= S_RL_CMP;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_RL_RD;
          end
        end
        S_RL_CMP: begin
          if (!found_r || alu_lt) begin
            best_r  <= hgt_d;
            found_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          st_r  <= S_RL_RD;
        end
        S_RL_END: begin
          // no residual slot ends the discharge
          if (!found_r) begin
            st_r <= S_END_D;
          end else begin
            hu_r    <= newh;
            steps_r <= steps_r + 1'b1;
            st_r    <= S_CHK;
          end
        end
        S_END_D: st_r <= S_LOOP;
        S_SUM_RD: begin
          if (idx_r == degs_r) st_r <= S_FIN;
          else                 st_r <= S_SUM_ADD;
        end
        S_SUM_ADD: begin
          total_r <= alu_res;
          idx_r   <= idx_r + 1'b1;
          st_r    <= S_SUM_RD;
        end
        S_FIN: begin
          if (total_r[DATA_W-1]) begin
            res_flow_r <= '0;
          end else if (total_r > {{(DATA_W-OUT_FLOW_W){1'b0}}, FLOW_OUT_MAX}) begin
            res_flow_r <= FLOW_OUT_MAX;
          end else begin
            res_flow_r <= total_r[OUT_FLOW_W-1:0];
          end
          res_status_r <= (iters_r >= lim_r) ? ST_LIMIT : ST_OK;
          res_iter_r   <= iters_r;
          st_r         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_flow_r   <= res_flow_r;
            out_status_r <= res_status_r;
            out_iter_r   <= res_iter_r;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready            = (st_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_max_flow        = out_flow_r;
  assign out_status          = out_status_r;
  assign out_iteration_count = out_iter_r;

`ifndef SYNTHESIS
  a_qcnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(qflag_r) == int'(qcnt_r))
    else $error("queue count disagrees with queued flags");

  a_push_amount: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PS_W1) |-> (amt_r != '0))
    else $error("push of zero amount");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LOOP) |-> (iters_r <= lim_r))
    else $error("pop count beyond limit");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == S_DONE))
    else $error("result raised outside result stage");
`endif

endmodule
